// ===== hdl/mrh_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the multiset range hash
`default_nettype none
package mrh_pkg;

   localparam int MAX_ITEMS_DEF  = 1024;
   localparam int VALUE_BITS_DEF = 20;

   localparam int HASH_W   = 30;
   localparam int IDX_W    = 10;
   localparam int ELEM_W   = 20;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;

   localparam logic [HASH_W-1:0] MOD_A  = 30'd1000004023;
   localparam logic [HASH_W-1:0] MOD_B  = 30'd1000000007;
   localparam logic [HASH_W-1:0] BASE_A = 30'd31;
   localparam logic [HASH_W-1:0] BASE_B = 30'd127;

   // barrett factors floor(2^60 / m)
   localparam logic [HASH_W:0] MU_A = 31'((64'd1 << 60) / {34'd0, MOD_A});
   localparam logic [HASH_W:0] MU_B = 31'((64'd1 << 60) / {34'd0, MOD_B});

   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REVERSED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef enum logic [1:0] {
      RD_PREV = 2'd0,
      RD_HI   = 2'd1,
      RD_LO   = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic                load_in;
      logic                pow_init;
      logic                mul_start;
      logic                pow_update;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                hold_hi;
      logic                append_done;
      logic                query_done;
      logic                clear_count;
      logic                set_result;
      logic [STATUS_W-1:0] result_status;
      logic                load_out;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              reversed;
      logic              beyond;
      logic              exp_zero;
      logic              mul_done;
      logic              out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== hdl/mrh_modmul.sv =====
// six-stage barrett modular multiplier for a fixed 30-bit modulus
`default_nettype none
module mrh_modmul #(
   parameter logic [29:0] MODULUS = mrh_pkg::MOD_A,
   parameter logic [30:0] MU      = mrh_pkg::MU_A
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [29:0] op_a,
   input  wire logic [29:0] op_b,
   output logic      [29:0] product,
   output logic             done
);

   logic [5:0]  valid_ff, valid_in;
   logic [59:0] p_ff, p_in;
   logic [61:0] q2_ff, q2_in;
   logic [31:0] plo2_ff, plo2_in;
   logic [31:0] t_ff, t_in;
   logic [31:0] plo3_ff, plo3_in;
   logic [31:0] r4_ff, r4_in;
   logic [31:0] r5_ff, r5_in;
   logic [31:0] r6_ff, r6_in;
   logic [60:0] tmul;

   assign p_in    = op_a * op_b;
   assign q2_in   = p_ff[59:29] * MU;
   assign plo2_in = p_ff[31:0];
   assign tmul    = q2_ff[61:31] * MODULUS;
   assign t_in    = tmul[31:0];
   assign plo3_in = plo2_ff;
   // remainder estimate is below three times the modulus
   assign r4_in   = plo3_ff - t_ff;
   assign r5_in   = (r4_ff >= {2'b00, MODULUS}) ? r4_ff - {2'b00, MODULUS} : r4_ff;
   assign r6_in   = (r5_ff >= {2'b00, MODULUS}) ? r5_ff - {2'b00, MODULUS} : r5_ff;
   assign valid_in = {valid_ff[4:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      q2_ff   <= q2_in;
      plo2_ff <= plo2_in;
      t_ff    <= t_in;
      plo3_ff <= plo3_in;
      r4_ff   <= r4_in;
      r5_ff   <= r5_in;
      r6_ff   <= r6_in;
   end

   assign product = r6_ff[29:0];
   assign done    = valid_ff[5];

endmodule
`default_nettype wire

// ===== hdl/mrh_datapath.sv =====
// datapath: item registers, prefix memory, power registers, multipliers and result register
`default_nettype none
module mrh_datapath #(
   parameter int MAX_ITEMS  = mrh_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_BITS = mrh_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mrh_pkg::cmd_type                  cmd,
   output mrh_pkg::stat_type                      stat,
   input  wire logic [mrh_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [mrh_pkg::FUNC_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [mrh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic      [mrh_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int HW     = mrh_pkg::HASH_W;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int CMP_W  = (CNT_W > mrh_pkg::IDX_W) ? CNT_W : mrh_pkg::IDX_W;
   localparam int EV_W   = (VALUE_BITS > mrh_pkg::ELEM_W) ? VALUE_BITS : mrh_pkg::ELEM_W;

   logic [mrh_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [VALUE_BITS-1:0]        exp_ff, exp_in;
   logic [mrh_pkg::IDX_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [HW-1:0]                acc_a_ff, acc_a_in, sq_a_ff, sq_a_in;
   logic [HW-1:0]                acc_b_ff, acc_b_in, sq_b_ff, sq_b_in;
   logic [2*HW-1:0]              hold_ff, hold_in;
   logic [2*HW-1:0]              rd_data_ff;
   logic [HW-1:0]                res_a_ff, res_a_in, res_b_ff, res_b_in;
   logic [mrh_pkg::STATUS_W-1:0] res_st_ff, res_st_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2*HW-1:0]              rsp_data_ff, rsp_data_in;
   logic [mrh_pkg::STATUS_W-1:0] rsp_st_ff, rsp_st_in;

   logic [2*HW-1:0] mem [MAX_ITEMS];

   logic [EV_W-1:0]   ev_ext;
   logic [CMP_W-1:0]  hi_ext, lo_m1, cnt_ext;
   logic [CNT_W-1:0]  cnt_m1;
   logic [ADDR_W-1:0] rd_addr;
   logic [HW-1:0]     prod_acc_a, prod_sq_a, prod_acc_b, prod_sq_b;
   logic [3:0]        mul_done;
   logic [HW-1:0]     prev_a, prev_b;
   logic [HW:0]       sum_a, sum_b, dif_a, dif_b;
   logic [HW-1:0]     red_sum_a, red_sum_b, red_dif_a, red_dif_b;

   assign ev_ext  = EV_W'(req_tdata[19:0]);
   assign hi_ext  = CMP_W'(hi_ff);
   assign lo_m1   = CMP_W'(lo_ff) - CMP_W'(1);
   assign cnt_ext = CMP_W'(count_ff);
   assign cnt_m1  = count_ff - CNT_W'(1);

   always_comb begin
      case (cmd.rd_sel)
         mrh_pkg::RD_HI: rd_addr = hi_ext[ADDR_W-1:0];
         mrh_pkg::RD_LO: rd_addr = lo_m1[ADDR_W-1:0];
         default:        rd_addr = cnt_m1[ADDR_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.append_done) begin
         mem[count_ff[ADDR_W-1:0]] <= {res_b_in, res_a_in};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   mrh_modmul #(.MODULUS(mrh_pkg::MOD_A), .MU(mrh_pkg::MU_A)) u_mul_acc_a (
      .clock(clock), .reset(reset), .start(cmd.mul_start),
      .op_a(acc_a_ff), .op_b(sq_a_ff), .product(prod_acc_a), .done(mul_done[0]));
   mrh_modmul #(.MODULUS(mrh_pkg::MOD_A), .MU(mrh_pkg::MU_A)) u_mul_sq_a (
      .clock(clock), .reset(reset), .start(cmd.mul_start),
      .op_a(sq_a_ff), .op_b(sq_a_ff), .product(prod_sq_a), .done(mul_done[1]));
   mrh_modmul #(.MODULUS(mrh_pkg::MOD_B), .MU(mrh_pkg::MU_B)) u_mul_acc_b (
      .clock(clock), .reset(reset), .start(cmd.mul_start),
      .op_a(acc_b_ff), .op_b(sq_b_ff), .product(prod_acc_b), .done(mul_done[2]));
   mrh_modmul #(.MODULUS(mrh_pkg::MOD_B), .MU(mrh_pkg::MU_B)) u_mul_sq_b (
      .clock(clock), .reset(reset), .start(cmd.mul_start),
      .op_a(sq_b_ff), .op_b(sq_b_ff), .product(prod_sq_b), .done(mul_done[3]));

   // first append has no earlier prefix
   assign prev_a = (count_ff != '0) ? rd_data_ff[HW-1:0]    : '0;
   assign prev_b = (count_ff != '0) ? rd_data_ff[2*HW-1:HW] : '0;
   assign sum_a  = {1'b0, acc_a_ff} + {1'b0, prev_a};
   assign sum_b  = {1'b0, acc_b_ff} + {1'b0, prev_b};
   assign red_sum_a = (sum_a >= {1'b0, mrh_pkg::MOD_A}) ? HW'(sum_a - {1'b0, mrh_pkg::MOD_A})
                                                        : sum_a[HW-1:0];
   assign red_sum_b = (sum_b >= {1'b0, mrh_pkg::MOD_B}) ? HW'(sum_b - {1'b0, mrh_pkg::MOD_B})
                                                        : sum_b[HW-1:0];
   assign dif_a = {1'b0, hold_ff[HW-1:0]} + {1'b0, mrh_pkg::MOD_A}
                  - {1'b0, rd_data_ff[HW-1:0]};
   assign dif_b = {1'b0, hold_ff[2*HW-1:HW]} + {1'b0, mrh_pkg::MOD_B}
                  - {1'b0, rd_data_ff[2*HW-1:HW]};
   assign red_dif_a = (dif_a >= {1'b0, mrh_pkg::MOD_A}) ? HW'(dif_a - {1'b0, mrh_pkg::MOD_A})
                                                        : dif_a[HW-1:0];
   assign red_dif_b = (dif_b >= {1'b0, mrh_pkg::MOD_B}) ? HW'(dif_b - {1'b0, mrh_pkg::MOD_B})
                                                        : dif_b[HW-1:0];

   always_comb begin
      func_in  = func_ff;
      exp_in   = exp_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      count_in = count_ff;
      acc_a_in = acc_a_ff;
      sq_a_in  = sq_a_ff;
      acc_b_in = acc_b_ff;
      sq_b_in  = sq_b_ff;
      hold_in  = hold_ff;
      res_a_in = res_a_ff;
      res_b_in = res_b_ff;
      res_st_in = res_st_ff;
      rsp_data_in = rsp_data_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (cmd.load_in) begin
         func_in = req_tuser;
         exp_in  = ev_ext[VALUE_BITS-1:0];
         lo_in   = req_tdata[29:20];
         hi_in   = req_tdata[39:30];
      end
      if (cmd.pow_init) begin
         acc_a_in = HW'(1);
         acc_b_in = HW'(1);
         sq_a_in  = mrh_pkg::BASE_A;
         sq_b_in  = mrh_pkg::BASE_B;
      end
      if (cmd.pow_update) begin
         if (exp_ff[0]) begin
            acc_a_in = prod_acc_a;
            acc_b_in = prod_acc_b;
         end
         sq_a_in = prod_sq_a;
         sq_b_in = prod_sq_b;
         exp_in  = exp_ff >> 1;
      end
      if (cmd.hold_hi) begin
         hold_in = rd_data_ff;
      end
      if (cmd.set_result) begin
         res_a_in  = '0;
         res_b_in  = '0;
         res_st_in = cmd.result_status;
      end
      if (cmd.append_done) begin
         res_a_in  = red_sum_a;
         res_b_in  = red_sum_b;
         res_st_in = mrh_pkg::ST_OK;
         count_in  = count_ff + CNT_W'(1);
      end
      if (cmd.query_done) begin
         res_a_in  = (lo_ff == '0) ? hold_ff[HW-1:0]    : red_dif_a;
         res_b_in  = (lo_ff == '0) ? hold_ff[2*HW-1:HW] : red_dif_b;
         res_st_in = mrh_pkg::ST_OK;
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end
      if (cmd.load_out) begin
         rsp_data_in  = {res_b_ff, res_a_ff};
         rsp_st_in    = res_st_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      exp_ff      <= exp_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      acc_a_ff    <= acc_a_in;
      sq_a_ff     <= sq_a_in;
      acc_b_ff    <= acc_b_in;
      sq_b_ff     <= sq_b_in;
      hold_ff     <= hold_in;
      res_a_ff    <= res_a_in;
      res_b_ff    <= res_b_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign stat.func     = func_ff;
   assign stat.full     = (count_ff == CNT_W'(MAX_ITEMS));
   assign stat.reversed = (hi_ff < lo_ff);
   assign stat.beyond   = (hi_ext >= cnt_ext);
   assign stat.exp_zero = (exp_ff == '0);
   assign stat.mul_done = &mul_done;
   assign stat.out_free = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mrh_pkg::RSP_DATA_W - 2*HW){1'b0}}, rsp_data_ff};
   assign rsp_tuser  = rsp_st_ff;

endmodule
`default_nettype wire

// ===== hdl/mrh_control.sv =====
// controller state machine sequencing append, query, clear and unused items
`default_nettype none
module mrh_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire mrh_pkg::stat_type stat,
   output mrh_pkg::cmd_type       cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_CHECK    = 8'b0000_0010,
      S_POW_MUL  = 8'b0000_0100,
      S_POW_WAIT = 8'b0000_1000,
      S_ADD      = 8'b0001_0000,
      S_Q_RD     = 8'b0010_0000,
      S_Q_SUB    = 8'b0100_0000,
      S_FINISH   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = mrh_pkg::RD_PREV;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_FINISH;
            case (stat.func)
               mrh_pkg::FUNC_APPEND: begin
                  if (stat.full) begin
                     cmd.set_result    = 1'b1;
                     cmd.result_status = mrh_pkg::ST_FULL;
                  end else begin
                     cmd.pow_init = 1'b1;
                     cmd.rd_en    = 1'b1;
                     state_in     = S_POW_MUL;
                  end
               end
               mrh_pkg::FUNC_QUERY: begin
                  // reversed range is reported ahead of the bounds check
                  if (stat.reversed) begin
                     cmd.set_result    = 1'b1;
                     cmd.result_status = mrh_pkg::ST_REVERSED;
                  end else if (stat.beyond) begin
                     cmd.set_result    = 1'b1;
                     cmd.result_status = mrh_pkg::ST_BEYOND;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = mrh_pkg::RD_HI;
                     state_in   = S_Q_RD;
                  end
               end
               mrh_pkg::FUNC_CLEAR: begin
                  cmd.clear_count   = 1'b1;
                  cmd.set_result    = 1'b1;
                  cmd.result_status = mrh_pkg::ST_OK;
               end
               default: begin
                  cmd.set_result    = 1'b1;
                  cmd.result_status = mrh_pkg::ST_OK;
               end
            endcase
         end
         S_POW_MUL: begin
            if (stat.exp_zero) begin
               state_in = S_ADD;
            end else begin
               cmd.mul_start = 1'b1;
               state_in      = S_POW_WAIT;
            end
         end
         S_POW_WAIT: begin
            if (stat.mul_done) begin
               cmd.pow_update = 1'b1;
               state_in       = S_POW_MUL;
            end
         end
         S_ADD: begin
            cmd.append_done = 1'b1;
            state_in        = S_FINISH;
         end
         S_Q_RD: begin
            cmd.hold_hi = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = mrh_pkg::RD_LO;
            state_in    = S_Q_SUB;
         end
         S_Q_SUB: begin
            cmd.query_done = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/multiset_range_hash.sv =====
// Multiset range hash: each append adds 31^v mod 1000004023 and 127^v mod 1000000007 to
// two running prefix sums kept in an on-chip memory; a range query returns the modular
// difference of two stored prefixes, a clear restarts the sequence. One item is worked on
// at a time. An append runs the square-and-multiply loop once per exponent bit up to the highest
// set bit of the value, around the six-stage Barrett multipliers; a query makes two reads of the
// single memory port. The result register lets the next item be taken while a result still waits
// on the output. Prefix memory needs no clearing pass.
`default_nettype none
module multiset_range_hash #(
   parameter int MAX_ITEMS  = mrh_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_BITS = mrh_pkg::VALUE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // element_value[19:0], first_index[29:20], last_index[39:30]
   input  wire logic [mrh_pkg::REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  wire logic [mrh_pkg::FUNC_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // hash_primary[29:0], hash_secondary[59:30], zero fill [63:60]
   output logic      [mrh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic      [mrh_pkg::STATUS_W-1:0]   rsp_tuser
);

   mrh_pkg::cmd_type  cmd;
   mrh_pkg::stat_type stat;

   mrh_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mrh_datapath #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== tb/multiset_range_hash_tb.sv =====
// self-checking testbench for the multiset range hash with its own prefix-sum predictor
`default_nettype none
module multiset_range_hash_tb;

   localparam int STORE_DEPTH = mrh_pkg::MAX_ITEMS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [mrh_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [mrh_pkg::FUNC_W-1:0] func;
      logic [mrh_pkg::ELEM_W-1:0] element_value;
      logic [mrh_pkg::IDX_W-1:0]  first_index;
      logic [mrh_pkg::IDX_W-1:0]  last_index;
   } hash_req_type;

   typedef struct packed {
      logic [mrh_pkg::HASH_W-1:0]   hash_primary;
      logic [mrh_pkg::HASH_W-1:0]   hash_secondary;
      logic [mrh_pkg::STATUS_W-1:0] status;
   } hash_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [mrh_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [mrh_pkg::FUNC_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [mrh_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [mrh_pkg::STATUS_W-1:0] rsp_tuser;

   multiset_range_hash dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   hash_req_type pending_reqs[$];
   hash_rsp_type expected_hashes[$];

   // predictor state
   logic [mrh_pkg::HASH_W-1:0] model_prefix_a[STORE_DEPTH];
   logic [mrh_pkg::HASH_W-1:0] model_prefix_b[STORE_DEPTH];
   int unsigned model_count = 0;

   int send_idle_pct = 16;
   int recv_idle_pct = 55;
   int hold_off_cycles = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [mrh_pkg::HASH_W-1:0] power_mod(
         input logic [63:0] base,
         input logic [mrh_pkg::ELEM_W-1:0] exponent,
         input logic [63:0] modulus);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1;
      sq = base % modulus;
      for (int i = 0; i < mrh_pkg::ELEM_W; i++) begin
         if (exponent[i])
            acc = (acc * sq) % modulus;
         sq = (sq * sq) % modulus;
      end
      return acc[mrh_pkg::HASH_W-1:0];
   endfunction

   function automatic hash_rsp_type predict_hash(input hash_req_type r);
      hash_rsp_type res;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] ma;
      logic [63:0] mb;
      ma = 64'(mrh_pkg::MOD_A);
      mb = 64'(mrh_pkg::MOD_B);
      res = '0;
      res.status = mrh_pkg::ST_OK;
      if (r.func == mrh_pkg::FUNC_APPEND) begin
         if (model_count >= STORE_DEPTH) begin
            res.status = mrh_pkg::ST_FULL;
         end else begin
            a = 64'(power_mod(64'(mrh_pkg::BASE_A), r.element_value, ma));
            b = 64'(power_mod(64'(mrh_pkg::BASE_B), r.element_value, mb));
            if (model_count != 0) begin
               a = (a + 64'(model_prefix_a[model_count-1])) % ma;
               b = (b + 64'(model_prefix_b[model_count-1])) % mb;
            end
            model_prefix_a[model_count] = a[mrh_pkg::HASH_W-1:0];
            model_prefix_b[model_count] = b[mrh_pkg::HASH_W-1:0];
            model_count++;
            res.hash_primary = a[mrh_pkg::HASH_W-1:0];
            res.hash_secondary = b[mrh_pkg::HASH_W-1:0];
         end
      end else if (r.func == mrh_pkg::FUNC_QUERY) begin
         if (r.last_index < r.first_index) begin
            res.status = mrh_pkg::ST_REVERSED;
         end else if (r.last_index >= model_count) begin
            res.status = mrh_pkg::ST_BEYOND;
         end else begin
            a = 64'(model_prefix_a[r.last_index]);
            b = 64'(model_prefix_b[r.last_index]);
            if (r.first_index != 0) begin
               a = (a + ma - 64'(model_prefix_a[r.first_index-1])) % ma;
               b = (b + mb - 64'(model_prefix_b[r.first_index-1])) % mb;
            end
            res.hash_primary = a[mrh_pkg::HASH_W-1:0];
            res.hash_secondary = b[mrh_pkg::HASH_W-1:0];
         end
      end else if (r.func == mrh_pkg::FUNC_CLEAR) begin
         model_count = 0;
      end
      return res;
   endfunction

   function automatic hash_req_type make_req(input logic [mrh_pkg::FUNC_W-1:0] f,
                                             input logic [mrh_pkg::ELEM_W-1:0] v,
                                             input logic [mrh_pkg::IDX_W-1:0] lo,
                                             input logic [mrh_pkg::IDX_W-1:0] hi);
      hash_req_type r;
      r.func = f;
      r.element_value = v;
      r.first_index = lo;
      r.last_index = hi;
      return r;
   endfunction

   function automatic logic [mrh_pkg::ELEM_W-1:0] rand_value();
      case ($urandom_range(0, 3))
         0: return mrh_pkg::ELEM_W'($urandom_range(0, 15));
         1: return ~mrh_pkg::ELEM_W'($urandom_range(0, 15));
         default: return mrh_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   task automatic add_req(input hash_req_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            hash_req_type r;
            r = pending_reqs[0];
            pending_reqs.delete(0);
            req_tvalid <= 1'b1;
            req_tuser <= r.func;
            req_tdata <= {r.last_index, r.first_index, r.element_value};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // predict on accepted transfers
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         hash_req_type r;
         r.func = req_tuser;
         r.element_value = req_tdata[19:0];
         r.first_index = req_tdata[29:20];
         r.last_index = req_tdata[39:30];
         expected_hashes = {expected_hashes, predict_hash(r)};
      end
   end

   // receiver readiness, with a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         hash_rsp_type got;
         hash_rsp_type want;
         got.hash_primary = rsp_tdata[29:0];
         got.hash_secondary = rsp_tdata[59:30];
         got.status = rsp_tuser;
         if (expected_hashes.size() == 0) begin
            $display("%0t: transfer expected none actual %h", $time, got);
            mismatches++;
         end else begin
            want = expected_hashes[0];
            expected_hashes.delete(0);
            if (got.hash_primary !== want.hash_primary) begin
               $display("%0t: hash_primary expected %0d actual %0d", $time,
                        want.hash_primary, got.hash_primary);
               mismatches++;
            end
            if (got.hash_secondary !== want.hash_secondary) begin
               $display("%0t: hash_secondary expected %0d actual %0d", $time,
                        want.hash_secondary, got.hash_secondary);
               mismatches++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, got.status);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else if (pending_reqs.size() != 0 || expected_hashes.size() != 0 || req_tvalid)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_hashes.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_random(input int count, input int fill_target);
      int shadow;
      shadow = 0;
      for (int i = 0; i < count; i++) begin
         int pick;
         int lo;
         int hi;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            add_req(make_req(mrh_pkg::FUNC_APPEND, rand_value(), '0, '0));
            if (shadow < STORE_DEPTH) shadow++;
         end else if (pick < 90 && shadow > 0) begin
            hi = $urandom_range(0, shadow - 1);
            lo = $urandom_range(0, hi);
            add_req(make_req(mrh_pkg::FUNC_QUERY, rand_value(),
                             mrh_pkg::IDX_W'(lo), mrh_pkg::IDX_W'(hi)));
         end else if (pick < 96) begin
            add_req(make_req(mrh_pkg::FUNC_QUERY, rand_value(),
                             mrh_pkg::IDX_W'($urandom), mrh_pkg::IDX_W'($urandom)));
         end else if (pick < 98 && shadow > fill_target) begin
            add_req(make_req(mrh_pkg::FUNC_CLEAR, rand_value(),
                             mrh_pkg::IDX_W'($urandom), mrh_pkg::IDX_W'($urandom)));
            shadow = 0;
         end else begin
            add_req(make_req(FUNC_UNUSED, rand_value(),
                             mrh_pkg::IDX_W'($urandom), mrh_pkg::IDX_W'($urandom)));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, extremes, reversed, beyond, unused code, clear
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd0, 10'd0));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd5, 10'd4));
      add_req(make_req(mrh_pkg::FUNC_APPEND, '0, '0, '0));
      add_req(make_req(mrh_pkg::FUNC_APPEND, '1, '0, '0));
      add_req(make_req(mrh_pkg::FUNC_APPEND, 20'd1, '0, '0));
      add_req(make_req(mrh_pkg::FUNC_APPEND, 20'h55555, '0, '0));
      add_req(make_req(mrh_pkg::FUNC_APPEND, 20'haaaaa, '0, '0));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '1, 10'd0, 10'd4));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd2, 10'd3));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd4, 10'd4));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd0, 10'd5));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd1023, 10'd1023));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd1023, 10'd0));
      add_req(make_req(FUNC_UNUSED, '1, '1, '1));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd0, 10'd4));
      add_req(make_req(mrh_pkg::FUNC_CLEAR, '1, '1, '1));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd0, 10'd0));
      add_req(make_req(mrh_pkg::FUNC_APPEND, 20'd7, '0, '0));
      add_req(make_req(mrh_pkg::FUNC_APPEND, 20'd7, '0, '0));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd1, 10'd1));
      add_req(make_req(mrh_pkg::FUNC_CLEAR, '0, '0, '0));
      wait_drained();

      // phase one: sender idles lightly, receiver heavily; long hold-off to fill the block
      hold_off_cycles = 400;
      queue_random(65, 1 << 30);
      wait_drained();

      // fill the store to the top with small exponents, then hit the full and edge cases
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_req(make_req(mrh_pkg::FUNC_CLEAR, '0, '0, '0));
      for (int i = 0; i < STORE_DEPTH; i++)
         add_req(make_req(mrh_pkg::FUNC_APPEND,
                          mrh_pkg::ELEM_W'($urandom_range(0, 3)), '0, '0));
      add_req(make_req(mrh_pkg::FUNC_APPEND, '1, '0, '0));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd0, 10'd1023));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd1023, 10'd1023));
      add_req(make_req(mrh_pkg::FUNC_QUERY, '0, 10'd512, 10'd700));
      add_req(make_req(mrh_pkg::FUNC_CLEAR, '0, '0, '0));
      wait_drained();

      // phase two: roles swapped
      send_idle_pct = 55;
      recv_idle_pct = 16;
      queue_random(65, 40);
      wait_drained();

      // phase three: no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(65, 40);
      wait_drained();

      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_hashes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire
